### rtl/core/tcmpq_pkg.sv
// Shared types and codes for the two-class max priority queue.
package tcmpq_pkg;

    localparam int KEY_W    = 8;
    localparam int STATUS_W = 2;

    // Operation codes carried by the func field
    typedef enum logic [1:0] {
        FUNC_INSERT     = 2'd0,
        FUNC_REMOVE_ANY = 2'd1,
        FUNC_REMOVE_A   = 2'd2,
        FUNC_REMOVE_B   = 2'd3
    } t_func;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Command broadcast to every cell of one queue row
    typedef struct packed {
        logic             ins;
        logic             pop;
        logic [KEY_W-1:0] key;
    } t_row_cmd;

endpackage

### rtl/core/tcmpq_cell.sv
// One compare-and-shift cell of a sorted queue row.
module tcmpq_cell (
    input  logic                         i_clk,
    input  tcmpq_pkg::t_row_cmd          i_cmd,
    input  logic                         i_occupied,
    input  logic                         i_prev_keep,
    input  logic [tcmpq_pkg::KEY_W-1:0]  i_prev_key,
    input  logic [tcmpq_pkg::KEY_W-1:0]  i_next_key,
    output logic [tcmpq_pkg::KEY_W-1:0]  o_key,
    output logic                         o_keep
);

    logic [tcmpq_pkg::KEY_W-1:0] r_key;
    logic [tcmpq_pkg::KEY_W-1:0] n_key;

    // Keep own key when it ranks at or above the new key
    assign o_keep = i_occupied && (r_key >= i_cmd.key);
    assign o_key  = r_key;

    // Take the new key at the insertion point, shift down below it, shift up on pop
    always_comb begin
        n_key = r_key;
        if (i_cmd.ins) begin
            if (o_keep) begin
                n_key = r_key;
            end else if (i_prev_keep) begin
                n_key = i_cmd.key;
            end else begin
                n_key = i_prev_key;
            end
        end else if (i_cmd.pop) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

### rtl/core/tcmpq_row.sv
// Row of cells holding one class queue, largest key at cell zero.
module tcmpq_row #(
    parameter int DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tcmpq_pkg::t_row_cmd          i_cmd,
    output logic [tcmpq_pkg::KEY_W-1:0]  o_head,
    output logic                         o_empty,
    output logic                         o_full
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;
    logic [tcmpq_pkg::KEY_W-1:0] w_key  [DEPTH];
    logic                        w_keep [DEPTH];

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_head  = w_key[0];

    // Chain the cells, each seeing its neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                        w_prev_keep;
        logic [tcmpq_pkg::KEY_W-1:0] w_prev_key;
        logic [tcmpq_pkg::KEY_W-1:0] w_next_key;

        if (g == 0) begin : g_first
            assign w_prev_keep = 1'b1;
            assign w_prev_key  = i_cmd.key;
        end else begin : g_mid
            assign w_prev_keep = w_keep[g-1];
            assign w_prev_key  = w_key[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next_key = w_key[g];
        end else begin : g_inner
            assign w_next_key = w_key[g+1];
        end

        tcmpq_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (i_cmd),
            .i_occupied  (CNT_W'(g) < r_count),
            .i_prev_keep (w_prev_keep),
            .i_prev_key  (w_prev_key),
            .i_next_key  (w_next_key),
            .o_key       (w_key[g]),
            .o_keep      (w_keep[g])
        );
    end

    // Advance the fill count
    always_comb begin
        n_count = r_count;
        if (i_cmd.ins && !o_full) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop && !o_empty) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_ins_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ins && o_full) |=> $stable(r_count))
        else $error("insert into full row changed count");

endmodule

### rtl/core/two_class_max_priority_queue.sv
// Top level of the two-class max priority queue.
// Each class is a row of QUEUE_DEPTH compare-and-shift cells kept sorted with the
// largest key in the head cell; the whole row completes an insert or a removal
// at once, so the block accepts one item per cycle and returns its result in
// the output register in the cycle after acceptance. The result register is the
// only storage between the channels: i_valid is taken while the result is taken or
// no result waits, so throughput is one item per cycle unless the output stalls.
// No clearing pass follows reset; the queues are empty as soon as reset is released.
module two_class_max_priority_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_func,
    input  logic [tcmpq_pkg::KEY_W-1:0]       i_key,
    input  logic                              i_class_a,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [tcmpq_pkg::STATUS_W-1:0]    o_status,
    output logic [tcmpq_pkg::KEY_W-1:0]       o_removed_key,
    output logic                              o_from_class_a
);

    tcmpq_pkg::t_row_cmd             w_cmd_a;
    tcmpq_pkg::t_row_cmd             w_cmd_b;
    logic [tcmpq_pkg::KEY_W-1:0]     w_head_a;
    logic [tcmpq_pkg::KEY_W-1:0]     w_head_b;
    logic                            w_empty_a;
    logic                            w_empty_b;
    logic                            w_full_a;
    logic                            w_full_b;
    logic                            w_accept;
    logic                            w_pick_a;
    logic                            w_pick_b;

    logic                            r_valid;
    logic [tcmpq_pkg::STATUS_W-1:0]  r_status;
    logic [tcmpq_pkg::KEY_W-1:0]     r_removed_key;
    logic                            r_from_class_a;
    logic [tcmpq_pkg::STATUS_W-1:0]  n_status;
    logic [tcmpq_pkg::KEY_W-1:0]     n_removed_key;
    logic                            n_from_class_a;

    // Hold the input while an untaken result waits
    assign o_stall  = r_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    // Decide the operation against both heads
    always_comb begin
        w_pick_a       = 1'b0;
        w_pick_b       = 1'b0;
        w_cmd_a        = '0;
        w_cmd_b        = '0;
        w_cmd_a.key    = i_key;
        w_cmd_b.key    = i_key;
        n_status       = tcmpq_pkg::ST_OK;
        n_removed_key  = '0;
        n_from_class_a = 1'b0;
        unique case (tcmpq_pkg::t_func'(i_func))
            tcmpq_pkg::FUNC_INSERT: begin
                if (i_class_a) begin
                    w_cmd_a.ins = w_accept && !w_full_a;
                    if (w_full_a) begin
                        n_status = tcmpq_pkg::ST_FULL;
                    end
                end else begin
                    w_cmd_b.ins = w_accept && !w_full_b;
                    if (w_full_b) begin
                        n_status = tcmpq_pkg::ST_FULL;
                    end
                end
            end
            tcmpq_pkg::FUNC_REMOVE_ANY: begin
                w_pick_a = !w_empty_a && (w_empty_b || (w_head_a >= w_head_b));
                w_pick_b = !w_pick_a && !w_empty_b;
            end
            tcmpq_pkg::FUNC_REMOVE_A: begin
                w_pick_a = !w_empty_a;
            end
            tcmpq_pkg::FUNC_REMOVE_B: begin
                w_pick_b = !w_empty_b;
            end
            default: begin
                w_pick_a = 1'b0;
            end
        endcase
        if (tcmpq_pkg::t_func'(i_func) != tcmpq_pkg::FUNC_INSERT) begin
            w_cmd_a.pop = w_accept && w_pick_a;
            w_cmd_b.pop = w_accept && w_pick_b;
            if (w_pick_a) begin
                n_removed_key  = w_head_a;
                n_from_class_a = 1'b1;
            end else if (w_pick_b) begin
                n_removed_key  = w_head_b;
            end else begin
                n_status = tcmpq_pkg::ST_EMPTY;
            end
        end
    end

    tcmpq_row #(
        .DEPTH (QUEUE_DEPTH)
    ) u_row_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_a),
        .o_head  (w_head_a),
        .o_empty (w_empty_a),
        .o_full  (w_full_a)
    );

    tcmpq_row #(
        .DEPTH (QUEUE_DEPTH)
    ) u_row_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_b),
        .o_head  (w_head_b),
        .o_empty (w_empty_b),
        .o_full  (w_full_b)
    );

    // Load the result register on accept, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status       <= n_status;
            r_removed_key  <= n_removed_key;
            r_from_class_a <= n_from_class_a;
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_removed_key  = r_removed_key;
    assign o_from_class_a = r_from_class_a;

    a_no_double_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd_a.pop && w_cmd_b.pop))
        else $error("both classes popped for one item");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != tcmpq_pkg::ST_OK) |-> (o_removed_key == '0 && !o_from_class_a))
        else $error("failed item reports a removed key");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == tcmpq_pkg::ST_OK || o_status == tcmpq_pkg::ST_EMPTY ||
                     o_status == tcmpq_pkg::ST_FULL))
        else $error("undefined status code");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("accepted item left no result");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the two-class max priority queue.
module tb;

    localparam int DEPTH       = 16;
    localparam int N_RANDOM    = 850;
    localparam int N_DIRECTED  = 24;
    localparam int MAX_REPORTS = 10;
    localparam int LONG_HOLD   = 80;

    typedef struct packed {
        logic [tcmpq_pkg::STATUS_W-1:0] status;
        logic [tcmpq_pkg::KEY_W-1:0]    removed_key;
        logic                           from_class_a;
    } t_queue_result;

    // One stimulus row; typed rows carry a hand-written result
    typedef struct {
        tcmpq_pkg::t_func            func;
        logic [tcmpq_pkg::KEY_W-1:0] key;
        logic                        class_a;
        bit                          typed;
        t_queue_result               result;
    } t_stim_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic [1:0]                     i_func;
    logic [tcmpq_pkg::KEY_W-1:0]    i_key;
    logic                           i_class_a;
    logic                           o_valid;
    logic                           i_stall;
    logic [tcmpq_pkg::STATUS_W-1:0] o_status;
    logic [tcmpq_pkg::KEY_W-1:0]    o_removed_key;
    logic                           o_from_class_a;

    // Shadow queues, ascending, largest key at the back
    logic [tcmpq_pkg::KEY_W-1:0] class_a_shadow[$];
    logic [tcmpq_pkg::KEY_W-1:0] class_b_shadow[$];
    t_queue_result               pending_results[$];

    int unsigned mismatch_count = 0;
    bit          sender_burst   = 1'b0;
    bit          receiver_burst = 1'b0;
    bit          long_hold_req  = 1'b0;
    int          no_gap_left    = 0;

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{tcmpq_pkg::FUNC_REMOVE_ANY, 8'hA5, 1'b1, 1'b1, '{tcmpq_pkg::ST_EMPTY, 8'h00, 1'b0}},
        '{tcmpq_pkg::FUNC_REMOVE_A,   8'hFF, 1'b1, 1'b1, '{tcmpq_pkg::ST_EMPTY, 8'h00, 1'b0}},
        '{tcmpq_pkg::FUNC_REMOVE_B,   8'h5A, 1'b0, 1'b1, '{tcmpq_pkg::ST_EMPTY, 8'h00, 1'b0}},
        '{tcmpq_pkg::FUNC_INSERT,     8'h00, 1'b1, 1'b1, '{tcmpq_pkg::ST_OK,    8'h00, 1'b0}},
        '{tcmpq_pkg::FUNC_INSERT,     8'hFF, 1'b0, 1'b1, '{tcmpq_pkg::ST_OK,    8'h00, 1'b0}},
        '{tcmpq_pkg::FUNC_REMOVE_ANY, 8'h3C, 1'b1, 1'b1, '{tcmpq_pkg::ST_OK,    8'hFF, 1'b0}},
        '{tcmpq_pkg::FUNC_REMOVE_ANY, 8'hC3, 1'b0, 1'b1, '{tcmpq_pkg::ST_OK,    8'h00, 1'b1}},
        '{tcmpq_pkg::FUNC_REMOVE_ANY, 8'h00, 1'b0, 1'b1, '{tcmpq_pkg::ST_EMPTY, 8'h00, 1'b0}},
        '{tcmpq_pkg::FUNC_INSERT,     8'h80, 1'b1, 1'b1, '{tcmpq_pkg::ST_OK,    8'h00, 1'b0}},
        '{tcmpq_pkg::FUNC_INSERT,     8'h80, 1'b0, 1'b1, '{tcmpq_pkg::ST_OK,    8'h00, 1'b0}},
        '{tcmpq_pkg::FUNC_REMOVE_ANY, 8'h7F, 1'b0, 1'b1, '{tcmpq_pkg::ST_OK,    8'h80, 1'b1}},
        '{tcmpq_pkg::FUNC_REMOVE_ANY, 8'hFF, 1'b1, 1'b1, '{tcmpq_pkg::ST_OK,    8'h80, 1'b0}},
        '{tcmpq_pkg::FUNC_INSERT,     8'h37, 1'b1, 1'b0, '0},
        '{tcmpq_pkg::FUNC_INSERT,     8'hC4, 1'b1, 1'b0, '0},
        '{tcmpq_pkg::FUNC_INSERT,     8'h37, 1'b1, 1'b0, '0},
        '{tcmpq_pkg::FUNC_INSERT,     8'h01, 1'b0, 1'b0, '0},
        '{tcmpq_pkg::FUNC_INSERT,     8'hFE, 1'b0, 1'b0, '0},
        '{tcmpq_pkg::FUNC_REMOVE_B,   8'h11, 1'b1, 1'b0, '0},
        '{tcmpq_pkg::FUNC_REMOVE_A,   8'hEE, 1'b0, 1'b0, '0},
        '{tcmpq_pkg::FUNC_REMOVE_ANY, 8'h55, 1'b1, 1'b0, '0},
        '{tcmpq_pkg::FUNC_REMOVE_A,   8'hAA, 1'b0, 1'b0, '0},
        '{tcmpq_pkg::FUNC_REMOVE_A,   8'h01, 1'b1, 1'b0, '0},
        '{tcmpq_pkg::FUNC_REMOVE_ANY, 8'h80, 1'b0, 1'b0, '0},
        '{tcmpq_pkg::FUNC_REMOVE_B,   8'h7E, 1'b1, 1'b0, '0}
    };

    two_class_max_priority_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_key          (i_key),
        .i_class_a      (i_class_a),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_removed_key  (o_removed_key),
        .o_from_class_a (o_from_class_a)
    );

    // Free-running clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Place a key after its equals so the shadow stays ascending
    function automatic void place_key(ref logic [tcmpq_pkg::KEY_W-1:0] keys[$],
                                      input logic [tcmpq_pkg::KEY_W-1:0] k);
        int slot;
        slot = keys.size();
        while (slot > 0 && keys[slot-1] > k)
            slot--;
        keys.insert(slot, k);
    endfunction

    // Apply one operation to the shadow queues and return its result
    function automatic t_queue_result apply_queue_op(tcmpq_pkg::t_func f,
                                                     logic [tcmpq_pkg::KEY_W-1:0] k,
                                                     logic to_a);
        t_queue_result r;
        logic          take_a;
        logic          take_b;
        r      = '0;
        r.status = tcmpq_pkg::ST_OK;
        take_a = 1'b0;
        take_b = 1'b0;
        case (f)
            tcmpq_pkg::FUNC_INSERT: begin
                if (to_a) begin
                    if (class_a_shadow.size() >= DEPTH)
                        r.status = tcmpq_pkg::ST_FULL;
                    else
                        place_key(class_a_shadow, k);
                end else begin
                    if (class_b_shadow.size() >= DEPTH)
                        r.status = tcmpq_pkg::ST_FULL;
                    else
                        place_key(class_b_shadow, k);
                end
            end
            tcmpq_pkg::FUNC_REMOVE_ANY: begin
                // class A wins ties between the heads
                take_a = class_a_shadow.size() > 0 &&
                         (class_b_shadow.size() == 0 ||
                          class_a_shadow[$] >= class_b_shadow[$]);
                take_b = !take_a && class_b_shadow.size() > 0;
            end
            tcmpq_pkg::FUNC_REMOVE_A: begin
                take_a = class_a_shadow.size() > 0;
            end
            default: begin
                take_b = class_b_shadow.size() > 0;
            end
        endcase
        if (take_a) begin
            r.removed_key  = class_a_shadow.pop_back();
            r.from_class_a = 1'b1;
        end else if (take_b) begin
            r.removed_key = class_b_shadow.pop_back();
        end else if (f != tcmpq_pkg::FUNC_INSERT) begin
            r.status = tcmpq_pkg::ST_EMPTY;
        end
        return r;
    endfunction

    // Offer one item after a random gap and hold it until taken
    task automatic offer_item(input tcmpq_pkg::t_func f,
                              input logic [tcmpq_pkg::KEY_W-1:0] k, input logic to_a,
                              input bit typed, input t_queue_result typed_result);
        int            gap;
        t_queue_result predicted;
        gap = (sender_burst || no_gap_left > 0) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_func    <= f;
        i_key     <= k;
        i_class_a <= to_a;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        predicted = apply_queue_op(f, k, to_a);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic note_mismatch(input string what, input t_queue_result want,
                                 input t_queue_result got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s: expected status %0d key %02h from_a %0d,",
                     $realtime, what, want.status, want.removed_key, want.from_class_a,
                     " got status %0d key %02h from_a %0d",
                     got.status, got.removed_key, got.from_class_a);
    endtask

    // Compare each taken result with the oldest expectation
    always @(posedge i_clk) begin
        t_queue_result got;
        t_queue_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.status       = o_status;
            got.removed_key  = o_removed_key;
            got.from_class_a = o_from_class_a;
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.removed_key !== want.removed_key ||
                    got.from_class_a !== want.from_class_a)
                    note_mismatch("result mismatch", want, got);
            end
        end
    end

    // Result side: stall for a random hold before each item, long hold on request
    initial begin
        int hold;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else begin
                hold = receiver_burst ? 0 : $urandom_range(0, 17);
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid)
                @(posedge i_clk);
        end
    end

    // Stimulus: directed table, then random phases that fill and drain the queues
    initial begin
        int                          sent;
        int                          phase_len;
        int                          insert_pct;
        int                          a_pct;
        bit                          narrow_keys;
        tcmpq_pkg::t_func            f;
        logic [tcmpq_pkg::KEY_W-1:0] k;
        logic                        to_a;

        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_func    <= tcmpq_pkg::FUNC_INSERT;
        i_key     <= '0;
        i_class_a <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            offer_item(directed_rows[r].func, directed_rows[r].key, directed_rows[r].class_a,
                       directed_rows[r].typed, directed_rows[r].result);

        sent = 0;
        while (sent < N_RANDOM) begin
            phase_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0:       insert_pct = 85;
                1:       insert_pct = 50;
                default: insert_pct = 15;
            endcase
            a_pct          = 25 * $urandom_range(0, 4);
            narrow_keys    = ($urandom_range(0, 3) == 0);
            sender_burst   = ($urandom_range(0, 3) == 0);
            receiver_burst = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < phase_len && sent < N_RANDOM; j++) begin
                // hold off the result side while items keep coming back to back
                if (sent == 300 || sent == 600) begin
                    long_hold_req = 1'b1;
                    no_gap_left   = 30;
                end
                if ($urandom_range(1, 100) <= insert_pct)
                    f = tcmpq_pkg::FUNC_INSERT;
                else
                    f = tcmpq_pkg::t_func'($urandom_range(1, 3));
                to_a = ($urandom_range(1, 100) <= a_pct);
                if (narrow_keys)
                    k = ($urandom_range(0, 1) ? 8'hFC : 8'h00) | 8'($urandom_range(0, 3));
                else
                    k = 8'($urandom_range(0, 255));
                offer_item(f, k, to_a, 1'b0, '0);
                if (no_gap_left > 0)
                    no_gap_left--;
                sent++;
            end
        end
        i_valid <= 1'b0;

        // Drain outstanding results before the final report
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
